/* design/vmp_pkg.sv */
// shared constants and pipeline types for the view matrix point projection
package vmp_pkg;

   localparam int CoefSlots  = 12;
   localparam int ClipW      = 58;   // signed clip value, 2^-24 units
   localparam int MagW       = 57;   // clip magnitude
   localparam int ScaleW     = 22;   // half size in q.8
   localparam int NumW       = 79;   // magnitude times scale
   localparam int QuotW      = 40;   // quotient bits below the cap
   localparam int RemW       = 58;   // partial remainder
   localparam int DivStages  = 40;
   localparam int OffW       = 43;   // signed offset and sum before saturation

   localparam logic OP_PROJECT = 1'b0;
   localparam logic OP_LOAD    = 1'b1;

   localparam logic [1:0] CSR_HALF_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HALF_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MIN_DEPTH   = 2'd2;

   typedef struct packed {
      logic [RemW-1:0]  rem;
      logic [QuotW-1:0] nq;    // dividend bits still to come, quotient bits shifted in
      logic             cap;
      logic             neg;
      logic             zero;
   } lane_type;

   typedef struct packed {
      logic             visible;
      logic [MagW-1:0]  den;
      lane_type         lx;
      lane_type         ly;
   } div_type;

endpackage

/* design/view_matrix_point_projection.sv */
// top level of the view matrix point projection pipeline
// Projects world points through the x, y and w columns of a view-projection
// matrix, one request per cycle while the result side does not stall. A load
// request writes one of twelve coefficients at the pipeline entry and gives
// no result; the next request already sees it. For a project request, five
// stages form the clip values and the dividend (products, sums, depth test and
// magnitude, scale product, scale sum), one stage checks the quotient cap,
// forty restoring divider stages each produce one quotient bit for x and for y
// in parallel, and the output register adds the screen centre and saturates.
// The whole pipeline moves as one; a stall on the result side freezes every
// stage and the request side.
// Configuration is sampled live and must only change while the block is idle.
module view_matrix_point_projection (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [3:0]           req_coef_index,
   input  logic signed [31:0]   req_coef_value,
   input  logic signed [31:0]   req_point_x,
   input  logic signed [31:0]   req_point_y,
   input  logic signed [31:0]   req_point_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_screen_x,
   output logic signed [31:0]   rsp_screen_y,
   output logic                 rsp_visible,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [16:0]          csr_wdata
);
   import vmp_pkg::*;

   // configuration
   logic [13:0] half_width_ff;
   logic [13:0] half_height_ff;
   logic [16:0] min_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff  <= 14'd960;
         half_height_ff <= 14'd540;
         min_depth_ff   <= 17'd655;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_HALF_WIDTH:  half_width_ff  <= csr_wdata[13:0];
            CSR_HALF_HEIGHT: half_height_ff <= csr_wdata[13:0];
            CSR_MIN_DEPTH:   min_depth_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // the whole pipeline advances unless a finished result is held back
   logic advance;
   logic accept;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // coefficient store, written at the entry
   logic [31:0] coef_ff [CoefSlots];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CoefSlots; i++) coef_ff[i] <= '0;
      end else if (accept && req_operation == OP_LOAD &&
                   req_coef_index < 4'(CoefSlots)) begin
         coef_ff[req_coef_index] <= req_coef_value;
      end
   end

   // stage 1: nine coefficient by coordinate products, three translations
   logic               s1_valid_ff;
   logic signed [63:0] s1_prod_ff [9];
   logic signed [31:0] s1_trans_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (advance) s1_valid_ff <= accept && req_operation == OP_PROJECT;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 3; c++) begin
            s1_prod_ff[3*c]   <= $signed(coef_ff[4*c])   * req_point_x;
            s1_prod_ff[3*c+1] <= $signed(coef_ff[4*c+1]) * req_point_y;
            s1_prod_ff[3*c+2] <= $signed(coef_ff[4*c+2]) * req_point_z;
            s1_trans_ff[c]    <= $signed(coef_ff[4*c+3]);
         end
      end
   end

   // stage 2: clip values, each product floored to 2^-24 units
   logic                    s2_valid_ff;
   logic signed [ClipW-1:0] s2_clip_ff [3];
   logic signed [63:0]      s2_sum_in [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s2_sum_in[c] = 64'(s1_trans_ff[c]) + (s1_prod_ff[3*c] >>> 8)
                      + (s1_prod_ff[3*c+1] >>> 8) + (s1_prod_ff[3*c+2] >>> 8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (advance) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 3; c++) s2_clip_ff[c] <= s2_sum_in[c][ClipW-1:0];
      end
   end

   // stage 3: depth test, magnitudes and signs
   logic                 s3_valid_ff;
   logic                 s3_visible_ff;
   logic [MagW-1:0]      s3_den_ff;
   logic [MagW-1:0]      s3_mag_ff [2];
   logic                 s3_neg_ff [2];
   logic                 s3_zero_ff [2];
   logic signed [ClipW-1:0] depth_limit;
   logic [ClipW-1:0]     s3_abs_in [2];

   assign depth_limit = $signed({{(ClipW-25){1'b0}}, min_depth_ff, 8'b0});

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         s3_abs_in[c] = s2_clip_ff[c][ClipW-1] ? -s2_clip_ff[c] : s2_clip_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (advance) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_visible_ff <= s2_clip_ff[2] >= depth_limit;
         s3_den_ff     <= s2_clip_ff[2][MagW-1:0];
         for (int c = 0; c < 2; c++) begin
            s3_mag_ff[c]  <= s3_abs_in[c][MagW-1:0];
            s3_neg_ff[c]  <= s2_clip_ff[c][ClipW-1];
            s3_zero_ff[c] <= s2_clip_ff[c] == '0;
         end
      end
   end

   // stage 4: magnitude times half size, split into two partial products
   logic               s4_valid_ff;
   logic               s4_visible_ff;
   logic [MagW-1:0]    s4_den_ff;
   logic [53:0]        s4_plo_ff [2];
   logic [46:0]        s4_phi_ff [2];
   logic               s4_neg_ff [2];
   logic               s4_zero_ff [2];
   logic [ScaleW-1:0]  scale [2];

   assign scale[0] = {half_width_ff, 8'b0};
   assign scale[1] = {half_height_ff, 8'b0};

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (advance) s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_visible_ff <= s3_visible_ff;
         s4_den_ff     <= s3_den_ff;
         for (int c = 0; c < 2; c++) begin
            s4_plo_ff[c]  <= 54'(s3_mag_ff[c][31:0]) * 54'(scale[c]);
            s4_phi_ff[c]  <= 47'(s3_mag_ff[c][MagW-1:32]) * 47'(scale[c]);
            s4_neg_ff[c]  <= s3_neg_ff[c];
            s4_zero_ff[c] <= s3_zero_ff[c];
         end
      end
   end

   // stage 5: dividend
   logic               s5_valid_ff;
   logic               s5_visible_ff;
   logic [MagW-1:0]    s5_den_ff;
   logic [NumW-1:0]    s5_num_ff [2];
   logic               s5_neg_ff [2];
   logic               s5_zero_ff [2];

   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else if (advance) s5_valid_ff <= s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_visible_ff <= s4_visible_ff;
         s5_den_ff     <= s4_den_ff;
         for (int c = 0; c < 2; c++) begin
            s5_num_ff[c]  <= {25'b0, s4_plo_ff[c]} + {s4_phi_ff[c], 32'b0};
            s5_neg_ff[c]  <= s4_neg_ff[c];
            s5_zero_ff[c] <= s4_zero_ff[c];
         end
      end
   end

   // divider entry: cap check, then one quotient bit per stage
   logic    div_valid_ff [DivStages+1];
   div_type div_ff [DivStages+1];
   div_type div0_in;

   always_comb begin
      div0_in.visible = s5_visible_ff;
      div0_in.den     = s5_den_ff;
      div0_in.lx.cap  = {18'b0, s5_num_ff[0]} >= {s5_den_ff, 40'b0};
      div0_in.lx.rem  = {19'b0, s5_num_ff[0][NumW-1:QuotW]};
      div0_in.lx.nq   = s5_num_ff[0][QuotW-1:0];
      div0_in.lx.neg  = s5_neg_ff[0];
      div0_in.lx.zero = s5_zero_ff[0];
      div0_in.ly.cap  = {18'b0, s5_num_ff[1]} >= {s5_den_ff, 40'b0};
      div0_in.ly.rem  = {19'b0, s5_num_ff[1][NumW-1:QuotW]};
      div0_in.ly.nq   = s5_num_ff[1][QuotW-1:0];
      div0_in.ly.neg  = s5_neg_ff[1];
      div0_in.ly.zero = s5_zero_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) div_valid_ff[0] <= 1'b0;
      else if (advance) div_valid_ff[0] <= s5_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) div_ff[0] <= div0_in;
   end

   function automatic lane_type div_step(lane_type l, logic [MagW-1:0] den);
      logic [RemW-1:0] t;
      lane_type        o;
      t = {l.rem[RemW-2:0], l.nq[QuotW-1]};
      o = l;
      if (t >= {1'b0, den}) begin
         o.rem = t - {1'b0, den};
         o.nq  = {l.nq[QuotW-2:0], 1'b1};
      end else begin
         o.rem = t;
         o.nq  = {l.nq[QuotW-2:0], 1'b0};
      end
      return o;
   endfunction

   for (genvar j = 0; j < DivStages; j++) begin : g_div
      div_type step_in;

      always_comb begin
         step_in    = div_ff[j];
         step_in.lx = div_step(div_ff[j].lx, div_ff[j].den);
         step_in.ly = div_step(div_ff[j].ly, div_ff[j].den);
      end

      always_ff @(posedge clock) begin
         if (reset) div_valid_ff[j+1] <= 1'b0;
         else if (advance) div_valid_ff[j+1] <= div_valid_ff[j];
      end

      always_ff @(posedge clock) begin
         if (advance) div_ff[j+1] <= step_in;
      end
   end

   // output stage: signed offset around the centre, saturated
   function automatic logic [31:0] place(lane_type l, logic [13:0] half, logic flip);
      logic [QuotW:0]          q;
      logic signed [OffW-1:0]  off;
      logic signed [OffW-1:0]  sum;
      q   = l.zero ? '0 : (l.cap ? {1'b1, {QuotW{1'b0}}} : {1'b0, l.nq});
      off = l.neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
      if (flip) sum = $signed({{(OffW-22){1'b0}}, half, 8'b0}) - off;
      else      sum = $signed({{(OffW-22){1'b0}}, half, 8'b0}) + off;
      if (sum > $signed(OffW'(32'sh7FFF_FFFF)))       return 32'h7FFF_FFFF;
      else if (sum < -$signed(OffW'(33'h0_8000_0000))) return 32'h8000_0000;
      else                                              return sum[31:0];
   endfunction

   logic              rsp_valid_ff;
   logic [31:0]       rsp_screen_x_ff;
   logic [31:0]       rsp_screen_y_ff;
   logic              rsp_visible_ff;
   logic              out_vis;

   assign out_vis = div_ff[DivStages].visible;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= div_valid_ff[DivStages];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_visible_ff  <= out_vis;
         rsp_screen_x_ff <= out_vis ? place(div_ff[DivStages].lx, half_width_ff, 1'b0)
                                    : '0;
         rsp_screen_y_ff <= out_vis ? place(div_ff[DivStages].ly, half_height_ff, 1'b1)
                                    : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_screen_x = rsp_screen_x_ff;
   assign rsp_screen_y = rsp_screen_y_ff;
   assign rsp_visible  = rsp_visible_ff;

endmodule

/* design/vmp_checker.sv */
// port checker for the view matrix point projection, with its bind
module vmp_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic signed [31:0]  rsp_screen_x,
   input logic signed [31:0]  rsp_screen_y,
   input logic                rsp_visible
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_screen_x) &&
      $stable(rsp_screen_y) && $stable(rsp_visible))
      else $error("stalled result changed");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_screen_x == 0 && rsp_screen_y == 0)
      else $error("invisible point with nonzero position");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while result held back");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present after reset");

endmodule

bind view_matrix_point_projection vmp_checker u_vmp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_screen_x (rsp_screen_x),
   .rsp_screen_y (rsp_screen_y),
   .rsp_visible  (rsp_visible)
);

/* tb/sv/view_matrix_point_projection_tb.sv */
// self-checking testbench for the view matrix point projection block
module view_matrix_point_projection_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vmp_pkg::*;

   // screen result expected for one project request
   typedef struct {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic               vis;
   } screen_point_type;

   // local copy of the matrix and screen settings, predicts each result
   class projection_scoreboard;
      logic [31:0]      coef [CoefSlots];
      logic [13:0]      half_w, half_h;
      logic [16:0]      depth_min;
      screen_point_type pending [$];
      int               errors;

      function void clear();
         foreach (coef[i]) coef[i] = '0;
         half_w = 14'd960;
         half_h = 14'd540;
         depth_min = 17'd655;
         errors = 0;
      endfunction

      function void set_csr(logic [1:0] idx, logic [16:0] val);
         case (idx)
            CSR_HALF_WIDTH:  half_w = val[13:0];
            CSR_HALF_HEIGHT: half_h = val[13:0];
            CSR_MIN_DEPTH:   depth_min = val;
            default: ;
         endcase
      endfunction

      // dot product of one column with the point, products floored to 2^-24
      function longint column_dot(int base, longint px, longint py, longint pz);
         longint s;
         s = longint'($signed(coef[base + 3]));
         s += (longint'($signed(coef[base])) * px) >>> 8;
         s += (longint'($signed(coef[base + 1])) * py) >>> 8;
         s += (longint'($signed(coef[base + 2])) * pz) >>> 8;
         return s;
      endfunction

      // sign(c) * trunc(|c| * half * 256 / w), magnitude capped at 2^40
      function longint offset_of(longint c, longint w, logic [13:0] half);
         logic [127:0] num, q;
         longint       mag;
         if (c == 0) return 0;
         mag = (c < 0) ? -c : c;
         if (w == 0) q = 128'd1 << 40;
         else begin
            num = 128'(mag) * 128'({half, 8'd0});
            q = num / 128'(w);
            if (q > (128'd1 << 40)) q = 128'd1 << 40;
         end
         return (c < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
      endfunction

      function logic signed [31:0] clamp32(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function void note_request(logic op, logic [3:0] idx, logic [31:0] cv,
                                 logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
         longint           cx, cy, cw;
         screen_point_type e;
         if (op == OP_LOAD) begin
            if (idx < CoefSlots) coef[idx] = cv;
            return;
         end
         cw = column_dot(8, x, y, z);
         if (cw < (longint'(depth_min) <<< 8)) begin
            e.sx = 0;
            e.sy = 0;
            e.vis = 1'b0;
         end else begin
            cx = column_dot(0, x, y, z);
            cy = column_dot(4, x, y, z);
            e.sx = clamp32((longint'(half_w) <<< 8) + offset_of(cx, cw, half_w));
            e.sy = clamp32((longint'(half_h) <<< 8) - offset_of(cy, cw, half_h));
            e.vis = 1'b1;
         end
         pending.push_back(e);
      endfunction

      function void check_result(logic signed [31:0] sx, logic signed [31:0] sy,
                                 logic vis);
         screen_point_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result x=%h y=%h v=%b", sx, sy, vis);
            return;
         end
         e = pending.pop_front();
         if (sx !== e.sx || sy !== e.sy || vis !== e.vis) begin
            errors++;
            if (errors <= 10)
               $display("result differs: expected x=%h y=%h v=%b, got x=%h y=%h v=%b",
                        e.sx, e.sy, e.vis, sx, sy, vis);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = OP_PROJECT;
   logic [3:0]         req_coef_index = '0;
   logic signed [31:0] req_coef_value = '0;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_screen_x;
   logic signed [31:0] rsp_screen_y;
   logic               rsp_visible;
   logic               csr_write_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [16:0]        csr_wdata = '0;

   projection_scoreboard board;
   bit                   calm_phase = 1'b0;  // no idling on either side
   bit                   hold_phase = 1'b0;  // receiver holds off for a long stretch

   always #6 clock = ~clock;

   view_matrix_point_projection u_dut (.*);

   // result side: random stall, long hold-off on request, check at each accept
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_screen_x, rsp_screen_y, rsp_visible);
   end

   initial begin
      int hold_count;
      hold_count = 0;
      forever begin
         @(posedge clock);
         if (hold_phase && hold_count < 200) begin
            hold_count++;
            rsp_stall <= 1'b1;
         end else if (calm_phase)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(99) < 34);
      end
   end

   // offer one request and hold it until accepted, random gaps before it outside
   // the calm phase; valid is dropped by the next gap or by drain
   task automatic send_request(logic op, logic [3:0] idx, logic [31:0] cv,
                               logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while (!calm_phase && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_coef_index <= idx;
      req_coef_value <= cv;
      req_point_x    <= x;
      req_point_y    <= y;
      req_point_z    <= z;
      do @(posedge clock); while (req_stall);
      board.note_request(op, idx, cv, x, y, z);
   endtask

   task automatic load_coef(int idx, logic [31:0] v);
      send_request(OP_LOAD, idx[3:0], v, '0, '0, '0);
   endtask

   task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      send_request(OP_PROJECT, $urandom, $urandom, x, y, z);
   endtask

   // stop offering, wait until every result is in, then let the pipeline drain
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [16:0] v);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= v;
      @(posedge clock);
      board.set_csr(idx, v);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // coordinate with a random magnitude class so sums cover small and huge
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(4095)) - 2048;
         default: return $signed($urandom_range(1 << 20)) - (1 << 19);
      endcase
   endfunction

   // typical perspective matrix with a random spread of values
   task automatic load_view_matrix();
      for (int i = 0; i < CoefSlots; i++) begin
         if ($urandom_range(9) == 0) load_coef(i, $urandom);
         else load_coef(i, $signed($urandom_range(1 << 25)) - (1 << 24));
      end
      // w column mostly depth driven, so points land in front of the eye
      load_coef(10, 32'h0100_0000);
   endtask

   task automatic random_phase(int n);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(19))
            0:       load_coef($urandom_range(15), $urandom);
            1:       load_view_matrix();
            default: project(rand_coord(), rand_coord(), rand_coord());
         endcase
      end
   endtask

   initial begin
      board = new();
      board.clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: cleared matrix gives w = 0, invisible under default depth
      project(32'h7fffffff, 32'h80000000, 32'h0);
      drain();
      // zero depth limit: zero w visible, positive saturation on both axes and bare centre
      write_csr(CSR_MIN_DEPTH, 17'd0);
      load_coef(3, 32'h7fffffff);
      load_coef(7, 32'h80000000);
      project(32'h0, 32'h0, 32'h0);
      load_coef(3, 32'h0);
      project(32'h1, 32'h1, 32'h1);
      // out-of-range slots are ignored
      load_coef(12, 32'hffffffff);
      load_coef(15, 32'h12345678);
      // identity-like matrix with extreme points, huge quotient capped
      load_coef(0, 32'h7fffffff);
      load_coef(5, 32'h80000000);
      load_coef(11, 32'h0000_0001);
      project(32'h7fffffff, 32'h7fffffff, 32'h80000000);
      project(32'h80000000, 32'h80000000, 32'h7fffffff);
      load_coef(10, 32'h0100_0000);
      load_coef(11, 32'h0);
      project(32'h100, 32'hffffff00, 32'h100);
      project(32'h7fffffff, 32'h80000000, 32'h7fffffff);
      project(32'h80000000, 32'h7fffffff, 32'h80000000);
      drain();

      // settings: three mixes of low, mid and maximum values across the registers
      write_csr(CSR_HALF_WIDTH, 17'd8192);
      write_csr(CSR_HALF_HEIGHT, 17'd0);
      write_csr(CSR_MIN_DEPTH, 17'd65536);
      load_view_matrix();
      random_phase(80);
      drain();
      write_csr(CSR_HALF_WIDTH, 17'h3fff);
      write_csr(CSR_HALF_HEIGHT, 17'h3fff);
      write_csr(CSR_MIN_DEPTH, 17'h1ffff);
      random_phase(40);
      drain();
      write_csr(CSR_HALF_WIDTH, 17'd0);
      write_csr(CSR_HALF_HEIGHT, 17'd8192);
      write_csr(CSR_MIN_DEPTH, 17'd1);
      random_phase(80);
      drain();

      // no idling, then receiver holds off while requests keep coming
      calm_phase = 1'b1;
      write_csr(CSR_HALF_WIDTH, 17'd960);
      write_csr(CSR_HALF_HEIGHT, 17'd540);
      write_csr(CSR_MIN_DEPTH, 17'd655);
      random_phase(100);
      hold_phase = 1'b1;
      random_phase(70);
      calm_phase = 1'b0;
      random_phase(85);
      drain();

      if (board.errors == 0)
         $display("view_matrix_point_projection: match");
      else
         $display("view_matrix_point_projection: mismatch");
      $finish;
   end

   initial begin
      #5ms;
      $display("view_matrix_point_projection: mismatch");
      $finish;
   end
endmodule

/* view_matrix_point_projection.f */
design/vmp_pkg.sv
design/view_matrix_point_projection.sv
design/vmp_checker.sv
tb/sv/view_matrix_point_projection_tb.sv
